// ===== rtl/sha256_block_compress_defines.svh =====
// ----------------------------------------------------------------------------
// sha256_block_compress_defines
// assertion macros used by the block compression core
// ----------------------------------------------------------------------------
`ifndef SHA256_BLOCK_COMPRESS_DEFINES_SVH
`define SHA256_BLOCK_COMPRESS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SBC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("sha256 block compress check failed");

// next-cycle implication, checked out of reset
`define SBC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sha256 block compress sequence check failed");

`endif

// ===== rtl/sha256bc_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256bc_pkg
// types, codes and round constants of the sha-256 block compression
// ----------------------------------------------------------------------------
package sha256bc_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MSG  = 1'b1;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  idx;
        logic [31:0] data;
    } t_req;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            unique case (t)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

endpackage

// ===== rtl/sha256bc_front.sv =====
// ----------------------------------------------------------------------------
// sha256bc_front
// request intake: unpacks the stream and queues requests for the core
// ----------------------------------------------------------------------------
module sha256bc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sha256bc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                                s_axis_tuser,
    output logic                                o_req_valid,
    input  logic                                i_req_ready,
    output sha256bc_pkg::t_req                  o_req
);

    sha256bc_pkg::t_req r_q [2];
    logic [1:0]         r_cnt, n_cnt;
    logic               r_wr, r_rd;
    logic               w_push, w_pop;
    sha256bc_pkg::t_req w_in;

    always_comb begin
        w_in.cmd  = s_axis_tuser;
        w_in.idx  = s_axis_tdata[2:0];
        w_in.data = s_axis_tdata[34:3];
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign o_req_valid   = (r_cnt != 2'd0);
    assign o_req         = r_q[r_rd];
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign w_pop         = o_req_valid && i_req_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_in;
        end
    end

endmodule

// ===== rtl/sha256bc_core.sv =====
// ----------------------------------------------------------------------------
// sha256bc_core
// executes requests: chaining loads, schedule fill, 64 rounds, chaining add, emit
// ----------------------------------------------------------------------------
`include "sha256_block_compress_defines.svh"

module sha256bc_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    output logic                                 o_req_ready,
    input  sha256bc_pkg::t_req                   i_req,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [sha256bc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                                 m_axis_tlast
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]  r_state;
    logic [3:0]  r_wcnt;
    logic [5:0]  r_round;
    logic [2:0]  r_idx;
    logic [31:0] r_chain [8];
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];

    logic [31:0] w_t1, w_t2, w_bs0, w_bs1, w_ch, w_maj, w_s0, w_s1, w_wnew;
    logic        w_pop, w_out_go;

    assign o_req_ready   = (r_state == ST_IDLE);
    assign w_pop         = i_req_valid && o_req_ready;
    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tdata  = {5'd0, r_idx, r_chain[r_idx]};
    assign m_axis_tlast  = (r_idx == 3'd7);
    assign w_out_go      = m_axis_tvalid && m_axis_tready;

    // round logic
    always_comb begin
        w_bs1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
              ^ {r_v[4][24:0], r_v[4][31:25]};
        w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_t1  = r_v[7] + w_bs1 + w_ch + sha256bc_pkg::round_k(r_round) + r_w[0];
        w_bs0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
              ^ {r_v[0][21:0], r_v[0][31:22]};
        w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t2  = w_bs0 + w_maj;
        w_s0  = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]}
              ^ {3'd0, r_w[1][31:3]};
        w_s1  = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
              ^ {10'd0, r_w[14][31:10]};
        w_wnew = r_w[0] + w_s0 + r_w[9] + w_s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wcnt  <= 4'd0;
            r_round <= 6'd0;
            r_idx   <= 3'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_pop && i_req.cmd == sha256bc_pkg::CMD_MSG) begin
                        r_wcnt <= r_wcnt + 4'd1;
                        if (r_wcnt == 4'd15) begin
                            r_state <= ST_ROUND;
                            r_round <= 6'd0;
                        end
                    end
                end
                ST_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_idx   <= 3'd0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_out_go) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= 32'd0;
            end
        end else if (r_state == ST_IDLE && w_pop && i_req.cmd == sha256bc_pkg::CMD_MSG
                     && r_wcnt == 4'd15) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (r_state == ST_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_req.cmd == sha256bc_pkg::CMD_MSG) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= i_req.data;
        end else if (r_state == ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_wnew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_req.cmd == sha256bc_pkg::CMD_LOAD) begin
            r_chain[i_req.idx] <= i_req.data;
        end else if (r_state == ST_ADD) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_v[i];
            end
        end
    end

    `SBC_ASSERT_NEXT(a_rounds_end, (r_state == ST_ROUND && r_round == 6'd63), (r_state == ST_ADD))
    `SBC_ASSERT_NEXT(a_emit_start, (r_state == ST_ADD), (r_state == ST_EMIT && r_idx == 3'd0))
    `SBC_ASSERT_NEXT(a_emit_done, (w_out_go && r_idx == 3'd7), (r_state == ST_IDLE && r_wcnt == 4'd0))

endmodule

// ===== rtl/sha256_block_compress.sv =====
// ----------------------------------------------------------------------------
// sha256_block_compress
// sha-256 block compression with chaining word loads and message streaming
// ----------------------------------------------------------------------------
// a load or one of the first fifteen message words is taken by the core while it is idle
// the sixteenth word starts the rounds, then the add into the chaining words, then 8 output words
// the core takes no new request until the last output word of a 64-byte block is accepted
// a two-entry request queue takes up to two more requests while the rounds run
// reset (synchronous, active low) clears control state; chaining words are undefined until loaded
// ----------------------------------------------------------------------------
module sha256_block_compress (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // word_index[2:0], data_word[34:3], zero pad
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // hash_word[31:0], hash_index[34:32], zero pad
    output logic        m_axis_tlast
);

    logic               w_req_valid;
    logic               w_req_ready;
    sha256bc_pkg::t_req w_req;

    sha256bc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_req_valid   (w_req_valid),
        .i_req_ready   (w_req_ready),
        .o_req         (w_req)
    );

    sha256bc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (w_req_valid),
        .o_req_ready   (w_req_ready),
        .i_req         (w_req),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks sha256_block_compress against its own round-accurate digest model,
// with directed block tests, random blocks, random idling and backpressure
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic [31:0]  chain_q [8];
    logic [31:0]  msg_q [16];
    int           msg_count;
    t_digest_word digest_queue [$];
    int           fail_count;
    int           quiet_cycles;
    bit           sink_idle_on;
    bit           src_idle_on;
    int           sink_hold;

    sha256_block_compress dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] k_const(input int t);
        logic [31:0] kt [64];
        kt = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return kt[t];
    endfunction

    // update the digest model with one request, queue the digest words on a full block
    task automatic predict_digest(input logic cmd, input logic [2:0] idx,
                                  input logic [31:0] data);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        t_digest_word dw;
        if (cmd == sha256bc_pkg::CMD_LOAD) begin
            chain_q[idx] = data;
            return;
        end
        msg_q[msg_count] = data;
        if (msg_count != 15) begin
            msg_count++;
            return;
        end
        msg_count = 0;
        for (int t = 0; t < 16; t++) w[t] = msg_q[t];
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = chain_q[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(t) + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            chain_q[i] = chain_q[i] + v[i];
            dw.word  = chain_q[i];
            dw.index = i[2:0];
            dw.last  = (i == 7);
            digest_queue.push_back(dw);
        end
    endtask

    task automatic send_request(input logic cmd, input logic [2:0] idx,
                                input logic [31:0] data);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'b0, data, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_digest(cmd, idx, data);
    endtask

    task automatic send_block(input bit extreme);
        for (int i = 0; i < 16; i++)
            send_request(sha256bc_pkg::CMD_MSG, 3'($urandom),
                         extreme ? ((i % 2) ? 32'hffffffff : 32'h0) : $urandom);
    endtask

    task automatic load_chain(input int mode);
        for (int i = 0; i < 8; i++)
            send_request(sha256bc_pkg::CMD_LOAD, i[2:0], mode == 0 ? 32'h0 :
                         mode == 1 ? 32'hffffffff : $urandom);
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed;
        load_chain(0);
        send_block(1'b1);
        load_chain(1);
        send_block(1'b1);
        load_chain(2);
        wait_drained();
    endtask

    task automatic test_load_mid_block;
        for (int i = 0; i < 7; i++) send_request(sha256bc_pkg::CMD_MSG, 3'd7, $urandom);
        send_request(sha256bc_pkg::CMD_LOAD, 3'd3, $urandom);
        send_request(sha256bc_pkg::CMD_LOAD, 3'd7, 32'hffffffff);
        for (int i = 0; i < 9; i++) send_request(sha256bc_pkg::CMD_MSG, 3'd0, $urandom);
    endtask

    task automatic test_backpressure;
        sink_hold = 300;
        send_block(1'b0);
        send_block(1'b0);
        wait_drained();
    endtask

    task automatic test_random(input int blocks);
        for (int b = 0; b < blocks; b++) begin
            if ($urandom_range(0, 3) == 0)
                send_request(sha256bc_pkg::CMD_LOAD, 3'($urandom), $urandom);
            send_block(1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_on) begin
            m_axis_tready <= ($urandom_range(0, 4) != 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_queue.size() == 0) begin
                $error("unexpected digest word %h", m_axis_tdata);
                fail_count++;
            end else begin
                exp_w = digest_queue.pop_front();
                if (m_axis_tdata[31:0] !== exp_w.word) begin
                    $error("hash_word exp %h got %h", exp_w.word, m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[34:32] !== exp_w.index) begin
                    $error("hash_index exp %0d got %0d", exp_w.index, m_axis_tdata[34:32]);
                    fail_count++;
                end
                if (m_axis_tlast !== exp_w.last) begin
                    $error("last_word exp %0d got %0d", exp_w.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= sha256bc_pkg::CMD_LOAD;
        m_axis_tready <= 1'b0;
        msg_count     = 0;
        fail_count    = 0;
        quiet_cycles  = 0;
        sink_hold     = 0;
        sink_idle_on  = 1'b1;
        src_idle_on   = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_load_mid_block();
        test_backpressure();
        test_random(15);
        sink_idle_on = 1'b0;
        src_idle_on  = 1'b0;
        test_random(4);
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && digest_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/sha256bc_pkg.sv
rtl/sha256bc_front.sv
rtl/sha256bc_core.sv
rtl/sha256_block_compress.sv
tb/tb.sv
